// ===== hdl/vn_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vn_pkg
// Shared constants and types for the vector normalization pipeline.
// ----------------------------------------------------------------------------
package vn_pkg;

	localparam int unsigned UNIT_W   = 16;  // width of a Q1.15 unit component
	localparam int unsigned FRAC_Q   = 15;  // quotient bits produced by the divider
	localparam int unsigned MAG_W    = 16;  // width of the reported length
	localparam int unsigned LANES    = 3;   // x, y, z
	localparam logic [FRAC_Q-1:0] UNIT_MAX = {FRAC_Q{1'b1}};

	// handshake between neighboring cells
	typedef struct packed {
		logic valid;
		logic ready;
	} vn_link_t;

endpackage
`default_nettype wire

// ===== hdl/vn_sqrt_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vn_sqrt_cell
// One digit of a restoring square root: two radicand bits in, one root bit out.
// ----------------------------------------------------------------------------
module vn_sqrt_cell import vn_pkg::*; #(
	parameter int unsigned W      = 16,
	parameter int unsigned SIDE_W = 52
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                up_valid,
	output      vn_link_t            up_link,
	input  wire logic [2*W-1:0]      n_in,
	input  wire logic [W-1:0]        rem_in,
	input  wire logic [W-1:0]        root_in,
	input  wire logic [SIDE_W-1:0]   side_in,
	input  wire logic                dn_ready,
	output      logic                dn_valid,
	output      logic [2*W-1:0]      n_out,
	output      logic [W-1:0]        rem_out,
	output      logic [W-1:0]        root_out,
	output      logic [SIDE_W-1:0]   side_out
);

	logic         valid_q;
	logic         adv;
	logic [W+1:0] rem_sh;
	logic [W+1:0] trial;
	logic [W+1:0] rem_diff;
	logic         ge;

	assign adv             = !valid_q || dn_ready;
	assign up_link.ready   = adv;
	assign up_link.valid   = up_valid;
	assign dn_valid        = valid_q;

	assign rem_sh   = {rem_in, n_in[2*W-1 -: 2]};
	assign trial    = {root_in, 2'b01};
	assign ge       = (rem_sh >= trial);
	assign rem_diff = rem_sh - trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (adv) begin
			valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && up_valid) begin
			n_out    <= {n_in[2*W-3:0], 2'b00};
			rem_out  <= ge ? rem_diff[W-1:0] : rem_sh[W-1:0];
			root_out <= {root_in[W-2:0], ge};
			side_out <= side_in;
		end
	end

endmodule
`default_nettype wire

// ===== hdl/vn_div_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vn_div_cell
// One quotient bit of a restoring division, for all three lanes at once.
// ----------------------------------------------------------------------------
module vn_div_cell import vn_pkg::*; #(
	parameter int unsigned W      = 16,
	parameter int unsigned SIDE_W = 23
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          up_valid,
	output      vn_link_t                      up_link,
	input  wire logic [LANES-1:0][W:0]         r_in,
	input  wire logic [LANES-1:0][FRAC_Q-1:0]  q_in,
	input  wire logic [W-1:0]                  m_in,
	input  wire logic [SIDE_W-1:0]             side_in,
	input  wire logic                          dn_ready,
	output      logic                          dn_valid,
	output      logic [LANES-1:0][W:0]         r_out,
	output      logic [LANES-1:0][FRAC_Q-1:0]  q_out,
	output      logic [W-1:0]                  m_out,
	output      logic [SIDE_W-1:0]             side_out
);

	logic                  valid_q;
	logic                  adv;
	logic [LANES-1:0][W:0] r_next;
	logic [LANES-1:0]      bit_next;

	assign adv           = !valid_q || dn_ready;
	assign up_link.ready = adv;
	assign up_link.valid = up_valid;
	assign dn_valid      = valid_q;

	// shift the partial remainder, subtract the divisor where it fits
	always_comb begin
		logic [W:0] r2;
		for (int i = 0; i < LANES; i++) begin
			r2 = {r_in[i][W-1:0], 1'b0};
			bit_next[i] = (r2 >= {1'b0, m_in});
			r_next[i]   = bit_next[i] ? (r2 - {1'b0, m_in}) : r2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (adv) begin
			valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && up_valid) begin
			for (int i = 0; i < LANES; i++) begin
				r_out[i] <= r_next[i];
				q_out[i] <= {q_in[i][FRAC_Q-2:0], bit_next[i]};
			end
			m_out    <= m_in;
			side_out <= side_in;
		end
	end

endmodule
`default_nettype wire

// ===== hdl/vector3_normalize.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Throughput: one vector per cycle while the output side accepts data; every stage holds one transaction and the
// chain of root and divider cells advances each cycle that the output side takes data.
// Reset: arst_n clears all valid flags asynchronously; payload registers are not reset.
// ----------------------------------------------------------------------------
// vector3_normalize
// Euclidean length and unit vector of a signed Q8.8 3D vector, fully pipelined.
// ----------------------------------------------------------------------------
module vector3_normalize import vn_pkg::*; #(
	parameter int unsigned COMPONENT_WIDTH = 16
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic s_tvalid,
	output      logic s_tready,
	// vec_x, vec_y, vec_z from the lowest bit up, zero padded to whole bytes
	input  wire logic [((3*COMPONENT_WIDTH+7)/8)*8-1:0] s_tdata,
	output      logic m_tvalid,
	input  wire logic m_tready,
	// unit_x, unit_y, unit_z, magnitude from the lowest bit up
	output      logic [3*UNIT_W+MAG_W-1:0] m_tdata,
	// was_zero
	output      logic m_tuser
);

	localparam int unsigned W      = COMPONENT_WIDTH;
	localparam int unsigned SQ_SIDE = 3*W + 4;        // abs values, signs, zero
	localparam int unsigned DV_SIDE = 2*LANES + 1 + MAG_W; // signs, sats, zero, magnitude

	// ---------------- stage 1: absolute values and signs ----------------
	logic [LANES-1:0][W-1:0] raw;
	logic [LANES-1:0][W-1:0] abs_s1;
	logic [LANES-1:0]        neg_s1;
	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	logic adv_s1, adv_s2, adv_s3, adv_s4, adv_s5;

	assign raw[0] = s_tdata[W-1:0];
	assign raw[1] = s_tdata[2*W-1:W];
	assign raw[2] = s_tdata[3*W-1:2*W];

	assign s_tready = adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv_s1) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && s_tvalid) begin
			for (int i = 0; i < LANES; i++) begin
				neg_s1[i] <= raw[i][W-1];
				// the most negative code maps to 2^(W-1), which still fits unsigned
				abs_s1[i] <= raw[i][W-1] ? (~raw[i] + 1'b1) : raw[i];
			end
		end
	end

	// ---------------- stage 2: squares ----------------
	logic [LANES-1:0][2*W-1:0] sq_s2;
	logic [LANES-1:0][W-1:0]   abs_s2;
	logic [LANES-1:0]          neg_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			for (int i = 0; i < LANES; i++) begin
				sq_s2[i] <= abs_s1[i] * abs_s1[i];
			end
			abs_s2 <= abs_s1;
			neg_s2 <= neg_s1;
		end
	end

	// ---------------- stage 3: sum of squares ----------------
	// the sum stays at or below 3 * 2^(2W-2), so 2W bits hold it exactly
	logic [2*W-1:0]          sum_s3;
	logic [LANES-1:0][W-1:0] abs_s3;
	logic [LANES-1:0]        neg_s3;
	logic                    zero_s3;
	logic [2*W-1:0]          sum_c;

	assign sum_c = sq_s2[0] + sq_s2[1] + sq_s2[2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (adv_s3) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s3 && valid_s2) begin
			sum_s3  <= sum_c;
			zero_s3 <= (sum_c == '0);
			abs_s3  <= abs_s2;
			neg_s3  <= neg_s2;
		end
	end

	// ---------------- root chain: one root bit per cell ----------------
	logic [W:0]                 sq_valid;
	logic [W:0]                 sq_ready;
	vn_link_t [W-1:0]           sq_link;
	logic [W:0][2*W-1:0]        sq_n;
	logic [W:0][W-1:0]          sq_rem;
	logic [W:0][W-1:0]          sq_root;
	logic [W:0][SQ_SIDE-1:0]    sq_side;

	assign sq_valid[0] = valid_s3;
	assign sq_n[0]     = sum_s3;
	assign sq_rem[0]   = '0;
	assign sq_root[0]  = '0;
	assign sq_side[0]  = {zero_s3, neg_s3, abs_s3};

	for (genvar k = 0; k < W; k++) begin : g_sqrt
		vn_sqrt_cell #(.W(W), .SIDE_W(SQ_SIDE)) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.up_valid (sq_valid[k]),
			.up_link  (sq_link[k]),
			.n_in     (sq_n[k]),
			.rem_in   (sq_rem[k]),
			.root_in  (sq_root[k]),
			.side_in  (sq_side[k]),
			.dn_ready (sq_ready[k+1]),
			.dn_valid (sq_valid[k+1]),
			.n_out    (sq_n[k+1]),
			.rem_out  (sq_rem[k+1]),
			.root_out (sq_root[k+1]),
			.side_out (sq_side[k+1])
		);
		assign sq_ready[k] = sq_link[k].ready;
	end

	// ---------------- stage 4: divider setup ----------------
	// a component at or above the truncated length saturates; otherwise the
	// first partial remainder is the component itself and stays below the divisor
	logic [LANES-1:0][W-1:0] sq_abs;
	logic [LANES-1:0]        sq_neg;
	logic                    sq_zero;
	logic [W-1:0]            mag_c;
	logic [MAG_W-1:0]        mag16_c;

	assign {sq_zero, sq_neg, sq_abs} = sq_side[W];
	assign mag_c = sq_root[W];

	if (W >= MAG_W) begin : g_mag_trunc
		assign mag16_c = mag_c[MAG_W-1:0];
	end else begin : g_mag_ext
		assign mag16_c = {{(MAG_W-W){1'b0}}, mag_c};
	end

	logic [LANES-1:0][W:0]        r_s4;
	logic [LANES-1:0]             sat_s4;
	logic [LANES-1:0]             neg_s4;
	logic [W-1:0]                 m_s4;
	logic [MAG_W-1:0]             mag_s4;
	logic                         zero_s4;

	assign sq_ready[W] = adv_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (adv_s4) begin
			valid_s4 <= sq_valid[W];
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s4 && sq_valid[W]) begin
			for (int i = 0; i < LANES; i++) begin
				sat_s4[i] <= (sq_abs[i] >= mag_c);
				r_s4[i]   <= {1'b0, sq_abs[i]};
			end
			neg_s4  <= sq_neg;
			m_s4    <= mag_c;
			mag_s4  <= mag16_c;
			zero_s4 <= sq_zero;
		end
	end

	// ---------------- divider chain: one quotient bit per cell ----------------
	logic [FRAC_Q:0]                         dv_valid;
	logic [FRAC_Q:0]                         dv_ready;
	vn_link_t [FRAC_Q-1:0]                   dv_link;
	logic [FRAC_Q:0][LANES-1:0][W:0]         dv_r;
	logic [FRAC_Q:0][LANES-1:0][FRAC_Q-1:0]  dv_q;
	logic [FRAC_Q:0][W-1:0]                  dv_m;
	logic [FRAC_Q:0][DV_SIDE-1:0]            dv_side;

	assign dv_valid[0] = valid_s4;
	assign dv_r[0]     = r_s4;
	assign dv_q[0]     = '0;
	assign dv_m[0]     = m_s4;
	assign dv_side[0]  = {mag_s4, zero_s4, sat_s4, neg_s4};
	assign adv_s4      = !valid_s4 || dv_ready[0];

	for (genvar k = 0; k < FRAC_Q; k++) begin : g_div
		vn_div_cell #(.W(W), .SIDE_W(DV_SIDE)) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.up_valid (dv_valid[k]),
			.up_link  (dv_link[k]),
			.r_in     (dv_r[k]),
			.q_in     (dv_q[k]),
			.m_in     (dv_m[k]),
			.side_in  (dv_side[k]),
			.dn_ready (dv_ready[k+1]),
			.dn_valid (dv_valid[k+1]),
			.r_out    (dv_r[k+1]),
			.q_out    (dv_q[k+1]),
			.m_out    (dv_m[k+1]),
			.side_out (dv_side[k+1])
		);
		assign dv_ready[k] = dv_link[k].ready;
	end

	// ---------------- stage 5: saturate, apply sign, zero, hold result ----------------
	logic [LANES-1:0]        dv_neg;
	logic [LANES-1:0]        dv_sat;
	logic                    dv_zero;
	logic [MAG_W-1:0]        dv_mag;
	logic [LANES-1:0][UNIT_W-1:0] unit_c;
	logic [LANES-1:0][UNIT_W-1:0] unit_s5;
	logic [MAG_W-1:0]        mag_s5;
	logic                    zero_s5;

	assign {dv_mag, dv_zero, dv_sat, dv_neg} = dv_side[FRAC_Q];
	assign dv_ready[FRAC_Q] = adv_s5;

	always_comb begin
		logic [UNIT_W-1:0] mag_q;
		for (int i = 0; i < LANES; i++) begin
			mag_q = {1'b0, (dv_sat[i] ? UNIT_MAX : dv_q[FRAC_Q][i])};
			if (dv_zero) begin
				unit_c[i] = '0;
			end else begin
				unit_c[i] = dv_neg[i] ? (~mag_q + 1'b1) : mag_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5 <= 1'b0;
		end else if (adv_s5) begin
			valid_s5 <= dv_valid[FRAC_Q];
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s5 && dv_valid[FRAC_Q]) begin
			unit_s5 <= unit_c;
			mag_s5  <= dv_zero ? '0 : dv_mag;
			zero_s5 <= dv_zero;
		end
	end

	// ---------------- stall chain: advance a stage when it is empty or its successor has room ----
	assign adv_s5 = !valid_s5 || m_tready;
	assign adv_s3 = !valid_s3 || sq_ready[0];
	assign adv_s2 = !valid_s2 || adv_s3;
	assign adv_s1 = !valid_s1 || adv_s2;

	assign m_tvalid = valid_s5;
	assign m_tdata  = {mag_s5, unit_s5[2], unit_s5[1], unit_s5[0]};
	assign m_tuser  = zero_s5;

endmodule
`default_nettype wire

// ===== hdl/vn_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vn_checker
// Port-level checks of the normalization block, bound to the top level.
// ----------------------------------------------------------------------------
module vn_checker import vn_pkg::*; (
	input wire logic                       clk,
	input wire logic                       arst_n,
	input wire logic                       m_tvalid,
	input wire logic                       m_tready,
	input wire logic [3*UNIT_W+MAG_W-1:0]  m_tdata,
	input wire logic                       m_tuser
);

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("output changed while stalled");

	// a zero vector gives an all-zero result
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata == '0)
		else $error("zero vector with nonzero result");

	// saturation keeps every unit component off the most negative code
	a_sat: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[15:0] != 16'h8000 && m_tdata[31:16] != 16'h8000
			&& m_tdata[47:32] != 16'h8000)
		else $error("unit component out of range");

	// a nonzero vector gives a nonzero unit vector
	a_dir: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata[47:0] != '0)
		else $error("nonzero vector with zero direction");

endmodule

bind vector3_normalize vn_checker u_vn_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
`default_nettype wire
